/* rtl/ppd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and constants of the planar pixel palette decoder
// Holds the plane word and pixel types, the register file type, the register
// indexes and the display mode codes.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int PixelsPerWord = 16;
  localparam int PixIdxW       = $clog2(PixelsPerWord);
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 4;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_DISPLAY_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PALETTE_0     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PALETTE_1     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PALETTE_2     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PALETTE_3     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PALETTE_GROUP = 3'd5;

  // Display modes.
  localparam logic [2:0] MODE_LO_PLANES_12 = 3'd0;
  localparam logic [2:0] MODE_LO_PLANES_34 = 3'd1;
  localparam logic [2:0] MODE_LO_16COLOR   = 3'd2;
  localparam logic [2:0] MODE_LO_16C_ALT   = 3'd3;
  localparam logic [2:0] MODE_HI_PLANES_12 = 3'd4;
  localparam logic [2:0] MODE_HI_PLANES_34 = 3'd5;
  localparam logic [2:0] MODE_HI_4COLOR    = 3'd6;
  localparam logic [2:0] MODE_HI_ALT       = 3'd7;

  typedef struct packed {
    logic [7:0] plane_one;
    logic [7:0] plane_two;
    logic [7:0] plane_three;
    logic [7:0] plane_four;
  } plane_word_t;

  typedef struct packed {
    logic [3:0] pixel_colour;
    logic       end_of_word;
  } pixel_t;

  typedef struct packed {
    logic [2:0]      display_mode;
    logic [3:0][3:0] palette;
    logic [1:0]      palette_group;
  } ppd_cfg_t;

endpackage

/* rtl/ppd_word_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_word_fifo: front queue of plane words
// Accepts video words from the push side and holds up to two of them for the
// pixel engine, so that both sides stall independently.
// ----------------------------------------------------------------------------
module ppd_word_fifo
  import ppd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  plane_word_t push_word,
  output logic        full,
  output logic        word_valid,
  output plane_word_t word,
  input  logic        word_pop
);

  plane_word_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full       = (count == 2'd2);
  assign word_valid = (count != 2'd0);
  assign word       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = word_pop && word_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* rtl/ppd_pixel_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pixel_engine: pixel sequencer, palette lookup and result queue
// Steps through the sixteen pixels of the current word, one per clock while
// the queue has room, maps each via mode and palette logic, queues it for pop.
// ----------------------------------------------------------------------------
module ppd_pixel_engine
  import ppd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ppd_cfg_t    cfg,
  input  logic        word_valid,
  input  plane_word_t word,
  output logic        word_pop,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  pixel_colour,
  output logic        end_of_word
);

  logic [PixIdxW-1:0] idx;
  pixel_t             outq [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               do_pop;
  logic               emit;
  logic               is_last;
  logic [3:0]         colour;

  assign empty        = (count == 2'd0);
  assign do_pop       = pop && !empty;
  assign emit         = word_valid && ((count != 2'd2) || do_pop);
  assign is_last      = (idx == PixIdxW'(PixelsPerWord - 1));
  assign word_pop     = emit && is_last;
  assign pixel_colour = outq[rd_ptr].pixel_colour;
  assign end_of_word  = outq[rd_ptr].end_of_word;

  // Low-resolution modes use each bit position twice; high-resolution modes
  // take plane one or three for the first eight pixels and two or four after.
  always_comb begin
    logic [2:0] b_lo;
    logic [2:0] b_hi;
    logic       odd;
    logic       a;
    logic       c;
    logic [3:0] code;
    b_lo   = idx[3:1];
    b_hi   = idx[2:0];
    odd    = idx[3];
    a      = 1'b0;
    c      = 1'b0;
    code   = 4'd0;
    colour = 4'd0;
    case (cfg.display_mode)
      MODE_LO_PLANES_12: begin
        colour = cfg.palette[{word.plane_two[b_lo], word.plane_one[b_lo]}];
      end
      MODE_LO_PLANES_34: begin
        colour = cfg.palette[{word.plane_four[b_lo], word.plane_three[b_lo]}];
      end
      MODE_LO_16COLOR, MODE_LO_16C_ALT: begin
        a = word.plane_three[b_lo];
        c = word.plane_four[b_lo];
        if ((cfg.display_mode == MODE_LO_16C_ALT) && (cfg.palette_group == {c, a})) begin
          code = {c, a, c, a};
        end else begin
          code = {c, a, word.plane_two[b_lo], word.plane_one[b_lo]};
        end
        if (cfg.palette_group == code[3:2]) begin
          colour = cfg.palette[code[1:0]];
        end else begin
          colour = code;
        end
      end
      MODE_HI_PLANES_12: begin
        a      = odd ? word.plane_two[b_hi] : word.plane_one[b_hi];
        colour = cfg.palette[{1'b0, a}];
      end
      MODE_HI_PLANES_34: begin
        a      = odd ? word.plane_four[b_hi] : word.plane_three[b_hi];
        colour = cfg.palette[{1'b0, a}];
      end
      MODE_HI_4COLOR: begin
        if (odd) begin
          colour = cfg.palette[{word.plane_four[b_hi], word.plane_two[b_hi]}];
        end else begin
          colour = cfg.palette[{word.plane_three[b_hi], word.plane_one[b_hi]}];
        end
      end
      default: begin
        a      = odd ? word.plane_four[b_hi] : word.plane_three[b_hi];
        colour = cfg.palette[{a, a}];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      outq[wr_ptr] <= '{pixel_colour: colour, end_of_word: is_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (emit) begin
        idx    <= idx + 1'b1;
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, emit} - {1'b0, do_pop};
    end
  end

endmodule

/* rtl/planar_pixel_palette_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_pixel_palette_decoder: planar video word to IGRB pixel stream
// Turns one four-plane video word into sixteen palette-mapped pixels.
// ----------------------------------------------------------------------------
// Each pushed word yields sixteen pixel words, least significant bit first,
// the sixteenth marked by end_of_word. The pixel engine produces one pixel per
// clock while a word is waiting and the output queue has room; a two-word
// input queue and a two-pixel output queue let the push and pop sides stall
// independently. Configuration writes are always taken (cfg_ready is high)
// and must only be issued while the block is idle; indexes beyond the
// register list are ignored.
module planar_pixel_palette_decoder
  import ppd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         plane_one,
  input  logic [7:0]         plane_two,
  input  logic [7:0]         plane_three,
  input  logic [7:0]         plane_four,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         pixel_colour,
  output logic               end_of_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  ppd_cfg_t    cfg;
  plane_word_t push_word;
  plane_word_t word;
  logic        word_valid;
  logic        word_pop;

  assign cfg_ready = 1'b1;
  assign push_word = '{plane_one: plane_one, plane_two: plane_two,
                       plane_three: plane_three, plane_four: plane_four};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DISPLAY_MODE:  cfg.display_mode  <= cfg_data[2:0];
        REG_PALETTE_0:     cfg.palette[0]    <= cfg_data;
        REG_PALETTE_1:     cfg.palette[1]    <= cfg_data;
        REG_PALETTE_2:     cfg.palette[2]    <= cfg_data;
        REG_PALETTE_3:     cfg.palette[3]    <= cfg_data;
        REG_PALETTE_GROUP: cfg.palette_group <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  ppd_word_fifo u_word_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (full),
    .word_valid (word_valid),
    .word       (word),
    .word_pop   (word_pop)
  );

  ppd_pixel_engine u_pixel_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .word_valid   (word_valid),
    .word         (word),
    .word_pop     (word_pop),
    .empty        (empty),
    .pop          (pop),
    .pixel_colour (pixel_colour),
    .end_of_word  (end_of_word)
  );

endmodule
